FILE: design/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define TPTR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tptr assertion failed");

// clocked assertion that also holds during reset
`define TPTR_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tptr reset assertion failed");

`endif

FILE: design/tptr_pkg.sv
// types, constants and helpers of the three-perceptron trainer
package tptr_pkg;

  localparam int FEAT_W       = 16;
  localparam int WGT_W        = 32;
  localparam int LR_W         = 16;
  localparam int CNT_W        = 11;
  localparam int PIX_W        = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;
  localparam int NUM_FEATURES = 4;
  localparam int NUM_OUT_W    = 2;
  localparam int MAX_SAMPLES  = 1024;
  localparam int STREAK_MAX   = 2047;

  localparam int PROD_W = FEAT_W + WGT_W;
  localparam int SUM_W  = PROD_W + 4;
  localparam int STEP_W = FEAT_W + LR_W + 1;
  localparam int EXT_W  = WGT_W + 2;

  localparam logic [CNT_W-1:0] STREAK_CAP =
    CNT_W'((MAX_SAMPLES < STREAK_MAX) ? MAX_SAMPLES : STREAK_MAX);

  localparam logic [LR_W-1:0]  LR_RESET = LR_W'(655);
  localparam logic [CNT_W-1:0] SC_RESET = CNT_W'(150);

  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = CFG_IDX_W'(1);

  localparam logic [PIX_W-1:0] PIX_A_W0   = PIX_W'(0);
  localparam logic [PIX_W-1:0] PIX_B_W0   = PIX_W'(4);
  localparam logic [PIX_W-1:0] PIX_C_W0   = PIX_W'(8);
  localparam logic [PIX_W-1:0] PIX_BIAS_A = PIX_W'(10);
  localparam logic [PIX_W-1:0] PIX_BIAS_B = PIX_W'(11);
  localparam logic [PIX_W-1:0] PIX_BIAS_C = PIX_W'(12);

  localparam logic signed [EXT_W-1:0] BIAS_STEP = EXT_W'(65536);
  localparam logic signed [EXT_W-1:0] WGT_HI = {3'b000, {(WGT_W-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] WGT_LO = {3'b111, {(WGT_W-1){1'b0}}};

  typedef logic signed [FEAT_W-1:0] feat_t;
  typedef feat_t [NUM_FEATURES-1:0] feat_vec_t;
  typedef logic signed [WGT_W-1:0]  wgt_t;

  typedef struct packed {
    logic [NUM_FEATURES-1:0] w_we;
    logic                    b_we;
  } hid_load_t;

  typedef struct packed {
    logic [NUM_OUT_W-1:0] w_we;
    logic                 b_we;
  } out_load_t;

  function automatic wgt_t sat_wgt(input logic signed [EXT_W-1:0] v);
    wgt_t r;
    if (v > WGT_HI) begin
      r = WGT_HI[WGT_W-1:0];
    end else if (v < WGT_LO) begin
      r = WGT_LO[WGT_W-1:0];
    end else begin
      r = v[WGT_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/tptr_ifs.sv
// item channels of the trainer: train or load items in, results out
interface tptr_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [tptr_pkg::FEAT_W-1:0]  feat0;
  logic signed [tptr_pkg::FEAT_W-1:0]  feat1;
  logic signed [tptr_pkg::FEAT_W-1:0]  feat2;
  logic signed [tptr_pkg::FEAT_W-1:0]  feat3;
  logic                                target_a;
  logic                                target_b;
  logic                                target_c;
  logic [tptr_pkg::PIX_W-1:0]          param_index;
  logic signed [tptr_pkg::WGT_W-1:0]   param_value;

  modport source (
    output valid, op, feat0, feat1, feat2, feat3, target_a, target_b, target_c,
           param_index, param_value,
    input  ready
  );
  modport sink (
    input  valid, op, feat0, feat1, feat2, feat3, target_a, target_b, target_c,
           param_index, param_value,
    output ready
  );
endinterface

interface tptr_out_if;
  logic valid;
  logic ready;
  logic out_a;
  logic out_b;
  logic out_c;
  logic miss_a;
  logic miss_b;
  logic miss_c;
  logic converged;

  modport source (
    output valid, out_a, out_b, out_c, miss_a, miss_b, miss_c, converged,
    input  ready
  );
  modport sink (
    input  valid, out_a, out_b, out_c, miss_a, miss_b, miss_c, converged,
    output ready
  );
endinterface

FILE: design/tptr_hidden.sv
// hidden neuron: four weights and a bias, hard limit and learning update
module tptr_hidden (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          train_en,
  input  tptr_pkg::hid_load_t           load,
  input  tptr_pkg::wgt_t                load_value,
  input  tptr_pkg::feat_vec_t           feats,
  input  logic [tptr_pkg::LR_W-1:0]     learn_rate,
  input  logic                          target,
  output logic                          out_bit,
  output logic                          miss
);

  tptr_pkg::wgt_t w_r    [tptr_pkg::NUM_FEATURES];
  tptr_pkg::wgt_t w_nxt  [tptr_pkg::NUM_FEATURES];
  tptr_pkg::wgt_t bias_r;
  tptr_pkg::wgt_t bias_nxt;

  logic signed [tptr_pkg::PROD_W-1:0] prod [tptr_pkg::NUM_FEATURES];
  logic signed [tptr_pkg::SUM_W-1:0]  acc;
  logic signed [tptr_pkg::STEP_W-1:0] raw  [tptr_pkg::NUM_FEATURES];
  logic signed [tptr_pkg::EXT_W-1:0]  rnd  [tptr_pkg::NUM_FEATURES];
  logic signed [tptr_pkg::EXT_W-1:0]  step [tptr_pkg::NUM_FEATURES];
  logic signed [tptr_pkg::EXT_W-1:0]  w_ext;
  logic signed [tptr_pkg::EXT_W-1:0]  b_ext;

  // exact Q28.24 sum and its sign
  always_comb begin
    acc = tptr_pkg::SUM_W'(bias_r) <<< 8;
    for (int j = 0; j < tptr_pkg::NUM_FEATURES; j++) begin
      prod[j] = tptr_pkg::PROD_W'(feats[j]) * tptr_pkg::PROD_W'(w_r[j]);
      acc     = acc + tptr_pkg::SUM_W'(prod[j]);
    end
  end

  assign out_bit = ~acc[tptr_pkg::SUM_W-1];
  assign miss    = out_bit != target;

  // step = feature * rate rounded half up to Q16.16
  always_comb begin
    for (int j = 0; j < tptr_pkg::NUM_FEATURES; j++) begin
      raw[j]  = tptr_pkg::STEP_W'(feats[j]) *
                $signed({{(tptr_pkg::STEP_W-tptr_pkg::LR_W){1'b0}}, learn_rate});
      rnd[j]  = tptr_pkg::EXT_W'(raw[j]) + tptr_pkg::EXT_W'(128);
      step[j] = rnd[j] >>> 8;
    end
  end

  always_comb begin
    for (int j = 0; j < tptr_pkg::NUM_FEATURES; j++) begin
      w_ext    = tptr_pkg::EXT_W'(w_r[j]);
      w_nxt[j] = tptr_pkg::sat_wgt(target ? (w_ext + step[j]) : (w_ext - step[j]));
    end
    b_ext    = tptr_pkg::EXT_W'(bias_r);
    bias_nxt = tptr_pkg::sat_wgt(target ? (b_ext + tptr_pkg::BIAS_STEP)
                                        : (b_ext - tptr_pkg::BIAS_STEP));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < tptr_pkg::NUM_FEATURES; j++) begin
        w_r[j] <= '0;
      end
      bias_r <= '0;
    end else begin
      for (int j = 0; j < tptr_pkg::NUM_FEATURES; j++) begin
        if (load.w_we[j]) begin
          w_r[j] <= load_value;
        end else if (train_en && miss) begin
          w_r[j] <= w_nxt[j];
        end
      end
      if (load.b_we) begin
        bias_r <= load_value;
      end else if (train_en && miss) begin
        bias_r <= bias_nxt;
      end
    end
  end

endmodule

FILE: design/tptr_outn.sv
// output neuron: weights on the two hidden outputs, bias, hard limit and update
module tptr_outn (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          train_en,
  input  tptr_pkg::out_load_t           load,
  input  tptr_pkg::wgt_t                load_value,
  input  logic                          in_a,
  input  logic                          in_b,
  input  logic [tptr_pkg::LR_W-1:0]     learn_rate,
  input  logic                          target,
  output logic                          out_bit,
  output logic                          miss
);

  tptr_pkg::wgt_t w_r   [tptr_pkg::NUM_OUT_W];
  tptr_pkg::wgt_t w_nxt [tptr_pkg::NUM_OUT_W];
  tptr_pkg::wgt_t bias_r;
  tptr_pkg::wgt_t bias_nxt;

  logic                              act [tptr_pkg::NUM_OUT_W];
  logic signed [tptr_pkg::EXT_W-1:0] acc;
  logic signed [tptr_pkg::EXT_W-1:0] lr_ext;
  logic signed [tptr_pkg::EXT_W-1:0] w_ext;
  logic signed [tptr_pkg::EXT_W-1:0] b_ext;

  assign act[0] = in_a;
  assign act[1] = in_b;
  assign lr_ext = $signed({{(tptr_pkg::EXT_W-tptr_pkg::LR_W){1'b0}}, learn_rate});

  always_comb begin
    acc = tptr_pkg::EXT_W'(bias_r);
    for (int j = 0; j < tptr_pkg::NUM_OUT_W; j++) begin
      if (act[j]) begin
        acc = acc + tptr_pkg::EXT_W'(w_r[j]);
      end
    end
  end

  assign out_bit = ~acc[tptr_pkg::EXT_W-1];
  assign miss    = out_bit != target;

  always_comb begin
    for (int j = 0; j < tptr_pkg::NUM_OUT_W; j++) begin
      w_ext    = tptr_pkg::EXT_W'(w_r[j]);
      w_nxt[j] = tptr_pkg::sat_wgt(target ? (w_ext + lr_ext) : (w_ext - lr_ext));
    end
    b_ext    = tptr_pkg::EXT_W'(bias_r);
    bias_nxt = tptr_pkg::sat_wgt(target ? (b_ext + tptr_pkg::BIAS_STEP)
                                        : (b_ext - tptr_pkg::BIAS_STEP));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < tptr_pkg::NUM_OUT_W; j++) begin
        w_r[j] <= '0;
      end
      bias_r <= '0;
    end else begin
      for (int j = 0; j < tptr_pkg::NUM_OUT_W; j++) begin
        if (load.w_we[j]) begin
          w_r[j] <= load_value;
        end else if (train_en && miss && act[j]) begin
          w_r[j] <= w_nxt[j];
        end
      end
      if (load.b_we) begin
        bias_r <= load_value;
      end else if (train_en && miss) begin
        bias_r <= bias_nxt;
      end
    end
  end

endmodule

FILE: design/tptr_streak.sv
// per-neuron streak counters and the converged flag
module tptr_streak (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       train_en,
  input  logic [2:0]                 miss,
  input  logic [tptr_pkg::CNT_W-1:0] sample_count,
  output logic                       converged
);

  logic [tptr_pkg::CNT_W-1:0] streak_r   [3];
  logic [tptr_pkg::CNT_W-1:0] streak_nxt [3];
  logic [tptr_pkg::CNT_W-1:0] limit;

  assign limit = (sample_count > tptr_pkg::STREAK_CAP) ? tptr_pkg::STREAK_CAP : sample_count;

  always_comb begin
    converged = 1'b1;
    for (int n = 0; n < 3; n++) begin
      if (!train_en) begin
        streak_nxt[n] = streak_r[n];
      end else if (miss[n]) begin
        streak_nxt[n] = '0;
      end else if (streak_r[n] < limit) begin
        streak_nxt[n] = streak_r[n] + tptr_pkg::CNT_W'(1);
      end else begin
        streak_nxt[n] = streak_r[n];
      end
      converged = converged & (streak_nxt[n] >= limit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < 3; n++) begin
        streak_r[n] <= '0;
      end
    end else begin
      for (int n = 0; n < 3; n++) begin
        streak_r[n] <= streak_nxt[n];
      end
    end
  end

endmodule

FILE: design/three_perceptron_online_trainer_unit.sv
// top level of the three-perceptron online trainer
//
// channel   direction  handshake     payload
// in_item   in         valid/ready   op, feat0-3, target_a-c, param_index, param_value
// out_item  out        valid/ready   out_a-c, miss_a-c, converged
// cfg       in         cfg_we        cfg_index, cfg_wdata
//
// one item per cycle unless stalled, via input register then result register
// each item reads, sums and writes back the neuron registers in the same cycle
// synchronous active-low reset zeroes weights, biases and streaks, restores config
// a stalled result holds the input register, and in_ready drops only then
module three_perceptron_online_trainer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tptr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tptr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  tptr_in_if.sink                         in_item,
  tptr_out_if.source                      out_item
);

  logic [tptr_pkg::LR_W-1:0]  learn_rate_r;
  logic [tptr_pkg::CNT_W-1:0] sample_count_r;

  // input register
  logic                       s1_valid_r;
  logic                       op_r;
  tptr_pkg::feat_vec_t        feats_r;
  logic [2:0]                 target_r;
  logic [tptr_pkg::PIX_W-1:0] pix_r;
  tptr_pkg::wgt_t             pval_r;

  // result register
  logic       out_valid_r;
  logic [2:0] out_bits_r;
  logic [2:0] miss_r;
  logic       conv_r;

  logic                s1_adv;
  logic                s1_fire;
  logic                train_en;
  logic                load_en;
  tptr_pkg::hid_load_t ld_a;
  tptr_pkg::hid_load_t ld_b;
  tptr_pkg::out_load_t ld_c;
  logic [2:0]          out_bits;
  logic [2:0]          miss;
  logic                converged;

  assign s1_adv        = !out_valid_r || out_item.ready;
  assign s1_fire       = s1_valid_r && s1_adv;
  assign train_en      = s1_fire && !op_r;
  assign load_en       = s1_fire && op_r;
  assign in_item.ready = !s1_valid_r || s1_adv;

  always_comb begin
    for (int j = 0; j < tptr_pkg::NUM_FEATURES; j++) begin
      ld_a.w_we[j] = load_en && (pix_r == tptr_pkg::PIX_A_W0 + tptr_pkg::PIX_W'(j));
      ld_b.w_we[j] = load_en && (pix_r == tptr_pkg::PIX_B_W0 + tptr_pkg::PIX_W'(j));
    end
    for (int j = 0; j < tptr_pkg::NUM_OUT_W; j++) begin
      ld_c.w_we[j] = load_en && (pix_r == tptr_pkg::PIX_C_W0 + tptr_pkg::PIX_W'(j));
    end
    ld_a.b_we = load_en && (pix_r == tptr_pkg::PIX_BIAS_A);
    ld_b.b_we = load_en && (pix_r == tptr_pkg::PIX_BIAS_B);
    ld_c.b_we = load_en && (pix_r == tptr_pkg::PIX_BIAS_C);
  end

  tptr_hidden u_hidden_a (
    .clk        (clk),
    .rst_n      (rst_n),
    .train_en   (train_en),
    .load       (ld_a),
    .load_value (pval_r),
    .feats      (feats_r),
    .learn_rate (learn_rate_r),
    .target     (target_r[0]),
    .out_bit    (out_bits[0]),
    .miss       (miss[0])
  );

  tptr_hidden u_hidden_b (
    .clk        (clk),
    .rst_n      (rst_n),
    .train_en   (train_en),
    .load       (ld_b),
    .load_value (pval_r),
    .feats      (feats_r),
    .learn_rate (learn_rate_r),
    .target     (target_r[1]),
    .out_bit    (out_bits[1]),
    .miss       (miss[1])
  );

  tptr_outn u_outn_c (
    .clk        (clk),
    .rst_n      (rst_n),
    .train_en   (train_en),
    .load       (ld_c),
    .load_value (pval_r),
    .in_a       (out_bits[0]),
    .in_b       (out_bits[1]),
    .learn_rate (learn_rate_r),
    .target     (target_r[2]),
    .out_bit    (out_bits[2]),
    .miss       (miss[2])
  );

  tptr_streak u_streak (
    .clk          (clk),
    .rst_n        (rst_n),
    .train_en     (train_en),
    .miss         (miss),
    .sample_count (sample_count_r),
    .converged    (converged)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r   <= tptr_pkg::LR_RESET;
      sample_count_r <= tptr_pkg::SC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tptr_pkg::CFG_LEARN_RATE:   learn_rate_r   <= cfg_wdata[tptr_pkg::LR_W-1:0];
        tptr_pkg::CFG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[tptr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_item.ready) begin
      s1_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      op_r       <= in_item.op;
      feats_r[0] <= in_item.feat0;
      feats_r[1] <= in_item.feat1;
      feats_r[2] <= in_item.feat2;
      feats_r[3] <= in_item.feat3;
      target_r   <= {in_item.target_c, in_item.target_b, in_item.target_a};
      pix_r      <= in_item.param_index;
      pval_r     <= in_item.param_value;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_bits_r <= op_r ? 3'b000 : out_bits;
      miss_r     <= op_r ? 3'b000 : miss;
      conv_r     <= converged;
    end
  end

  assign out_item.valid     = out_valid_r;
  assign out_item.out_a     = out_bits_r[0];
  assign out_item.out_b     = out_bits_r[1];
  assign out_item.out_c     = out_bits_r[2];
  assign out_item.miss_a    = miss_r[0];
  assign out_item.miss_b    = miss_r[1];
  assign out_item.miss_c    = miss_r[2];
  assign out_item.converged = conv_r;

endmodule

FILE: design/tptr_checker.sv
// port-level checker of the trainer and its bind to the top level
`include "assert_macros.svh"

module tptr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_a,
  input logic out_b,
  input logic out_c,
  input logic miss_a,
  input logic miss_b,
  input logic miss_c,
  input logic converged
);

  logic [6:0] res;

  assign res = {out_a, out_b, out_c, miss_a, miss_b, miss_c, converged};

  // a stalled result stays and holds its value
  `TPTR_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(res))

  // reset empties the result register
  `TPTR_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_valid)

  // an accepted item has a result waiting once it has passed the input and result registers
  `TPTR_ASSERT(a_accept_result, clk, rst_n, in_valid && in_ready |=> ##1 out_valid)

  // the input side stalls only behind a blocked result
  `TPTR_ASSERT(a_ready_backpressure, clk, rst_n, !in_ready |-> out_valid && !out_ready)

endmodule

bind three_perceptron_online_trainer_unit tptr_checker u_tptr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_item.valid),
  .in_ready  (in_item.ready),
  .out_valid (out_item.valid),
  .out_ready (out_item.ready),
  .out_a     (out_item.out_a),
  .out_b     (out_item.out_b),
  .out_c     (out_item.out_c),
  .miss_a    (out_item.miss_a),
  .miss_b    (out_item.miss_b),
  .miss_c    (out_item.miss_c),
  .converged (out_item.converged)
);
